@@ sv/fqos_pkg.sv @@
// Shared constants, payload types and controller/datapath interface structs.
package fqos_pkg;

    localparam int DEPTH     = 256;
    localparam int TAG_BITS  = 16;
    localparam int TIME_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int SUM_W     = 64;
    localparam int EXIT_W    = 32;
    localparam int ERR_W     = 2;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [TAG_BITS-1:0]  packet_tag;
        logic [TIME_BITS-1:0] now;
    } req_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]     out_tag;
        logic [TIME_BITS-1:0]    wait_time;
        logic [ERR_W-1:0]        error;
        logic [CNT_W-1:0]        queue_size;
        logic [CNT_W-1:0]        max_size;
        logic [SUM_W-1:0]        wait_sum;
        logic [EXIT_W-1:0]       exit_count;
        logic signed [SUM_W-1:0] area_sum;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic             load_item;
        logic             set_result;
        logic [ERR_W-1:0] err_code;
        logic             enq;
        logic             deq_read;
        logic             deq_wait;
        logic             deq_accum;
        logic             load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic mode;
        logic full;
        logic empty;
        logic out_free;
    } status_t;

endpackage

@@ sv/fifo_queue_with_occupancy_stats_core.sv @@
// Top level: packet FIFO with wait and occupancy statistics.
//
//   channel  dir  handshake           payload
//   req      in   req_valid/req_stall req   (mode, packet_tag, now)
//   rsp      out  rsp_valid/rsp_stall rsp   (tag, wait, error, statistics)
//
// An enqueue or a failed operation goes through the execute and emit states
// before it loads the result register; a successful dequeue adds the read and
// accumulate states: the storage read is registered and the wait subtraction
// and the 64-bit wait sum update sit in separate states. Emit waits for a free
// output register. One word is in work at a time; a new word is taken while
// the last result still waits in the output register. Reset clears pointers,
// counts and sums at once; the storage itself is not cleared.
module fifo_queue_with_occupancy_stats_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  fqos_pkg::req_t    req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output fqos_pkg::rsp_t    rsp
);

    fqos_pkg::cmd_t    cmd;
    fqos_pkg::status_t status;

    fqos_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    fqos_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("word accepted while another is in work");

    a_size_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.queue_size <= rsp.max_size))
        else $error("queue size above high-water mark");

    a_error_clears_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.error != fqos_pkg::ERR_NONE))
            |-> (rsp.out_tag == '0 && rsp.wait_time == '0))
        else $error("failed operation returned tag or wait");

    a_full_error_size: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.error == fqos_pkg::ERR_FULL))
            |-> (rsp.queue_size == fqos_pkg::CNT_W'(fqos_pkg::DEPTH)))
        else $error("full error while queue not full");

endmodule

@@ sv/fqos_datapath.sv @@
// Queue storage, pointers, statistics registers and the output register.
module fqos_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fqos_pkg::req_t       req,
    input  fqos_pkg::cmd_t       cmd,
    output fqos_pkg::status_t    status,
    input  logic                 rsp_stall,
    output logic                 rsp_valid,
    output fqos_pkg::rsp_t       rsp
);

    localparam int ENTRY_W = fqos_pkg::TAG_BITS + fqos_pkg::TIME_BITS;

    logic [ENTRY_W-1:0] mem [fqos_pkg::DEPTH];
    logic [ENTRY_W-1:0] rd_reg;

    fqos_pkg::req_t                 item_reg;
    logic [fqos_pkg::IDX_W-1:0]     head_reg, head_next;
    logic [fqos_pkg::IDX_W-1:0]     tail_reg, tail_next;
    logic [fqos_pkg::CNT_W-1:0]     occ_reg, occ_inc;
    logic [fqos_pkg::CNT_W-1:0]     high_reg;
    logic [fqos_pkg::SUM_W-1:0]     wait_sum_reg;
    logic [fqos_pkg::EXIT_W-1:0]    exits_reg;
    logic signed [fqos_pkg::SUM_W-1:0] area_reg;
    logic [fqos_pkg::TAG_BITS-1:0]  res_tag_reg;
    logic [fqos_pkg::TIME_BITS-1:0] res_wait_reg;
    logic [fqos_pkg::ERR_W-1:0]     res_err_reg;
    logic                           rsp_valid_reg;
    fqos_pkg::rsp_t                 rsp_reg;
    logic signed [fqos_pkg::SUM_W-1:0] now_ext;

    assign now_ext = $signed(fqos_pkg::SUM_W'(item_reg.now));
    assign occ_inc = occ_reg + fqos_pkg::CNT_W'(1);

    always_comb
    begin
        head_next = (head_reg == fqos_pkg::IDX_W'(fqos_pkg::DEPTH - 1))
                    ? '0 : head_reg + fqos_pkg::IDX_W'(1);
        tail_next = (tail_reg == fqos_pkg::IDX_W'(fqos_pkg::DEPTH - 1))
                    ? '0 : tail_reg + fqos_pkg::IDX_W'(1);
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.enq)
        begin
            mem[tail_reg] <= {item_reg.packet_tag, item_reg.now};
        end
        if (cmd.deq_read)
        begin
            rd_reg <= mem[head_reg];
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= req;
        end
        if (cmd.set_result)
        begin
            res_tag_reg  <= '0;
            res_wait_reg <= '0;
            res_err_reg  <= cmd.err_code;
        end
        else if (cmd.deq_wait)
        begin
            res_tag_reg  <= rd_reg[ENTRY_W-1 -: fqos_pkg::TAG_BITS];
            res_wait_reg <= item_reg.now - rd_reg[fqos_pkg::TIME_BITS-1:0];
        end
        if (cmd.load_out)
        begin
            rsp_reg.out_tag    <= res_tag_reg;
            rsp_reg.wait_time  <= res_wait_reg;
            rsp_reg.error      <= res_err_reg;
            rsp_reg.queue_size <= occ_reg;
            rsp_reg.max_size   <= high_reg;
            rsp_reg.wait_sum   <= wait_sum_reg;
            rsp_reg.exit_count <= exits_reg;
            rsp_reg.area_sum   <= area_reg;
        end
    end

    // pointers and statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            high_reg      <= '0;
            wait_sum_reg  <= '0;
            exits_reg     <= '0;
            area_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.enq)
            begin
                tail_reg <= tail_next;
                occ_reg  <= occ_inc;
                area_reg <= area_reg - now_ext;
                if (occ_inc > high_reg)
                begin
                    high_reg <= occ_inc;
                end
            end
            if (cmd.deq_accum)
            begin
                head_reg     <= head_next;
                occ_reg      <= occ_reg - fqos_pkg::CNT_W'(1);
                area_reg     <= area_reg + now_ext;
                wait_sum_reg <= wait_sum_reg + fqos_pkg::SUM_W'(res_wait_reg);
                exits_reg    <= exits_reg + fqos_pkg::EXIT_W'(1);
            end
            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign status.mode     = item_reg.mode;
    assign status.full     = (occ_reg == fqos_pkg::CNT_W'(fqos_pkg::DEPTH));
    assign status.empty    = (occ_reg == '0);
    assign status.out_free = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ sv/fqos_ctrl.sv @@
// Sequencer for one queue operation: accept, execute, read, accumulate, emit.
module fqos_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  fqos_pkg::status_t   status,
    output fqos_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_ACCUM,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.err_code = fqos_pkg::ERR_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.set_result = 1'b1;
                state_next     = S_EMIT;
                if (status.mode == fqos_pkg::MODE_ENQ)
                begin
                    if (status.full)
                    begin
                        cmd.err_code = fqos_pkg::ERR_FULL;
                    end
                    else
                    begin
                        cmd.enq = 1'b1;
                    end
                end
                else if (status.empty)
                begin
                    cmd.err_code = fqos_pkg::ERR_EMPTY;
                end
                else
                begin
                    cmd.deq_read = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                cmd.deq_wait = 1'b1;
                state_next   = S_ACCUM;
            end
            S_ACCUM:
            begin
                cmd.deq_accum = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the packet FIFO with wait and occupancy statistics.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 388;

    class queue_stats_scoreboard;
        logic [fqos_pkg::TAG_BITS-1:0]  held_tags[$];
        logic [fqos_pkg::TIME_BITS-1:0] held_times[$];
        logic [fqos_pkg::CNT_W-1:0]     peak_level;
        logic [fqos_pkg::SUM_W-1:0]     wait_total;
        logic [fqos_pkg::EXIT_W-1:0]    exits;
        logic [fqos_pkg::SUM_W-1:0]     area_total;
        fqos_pkg::rsp_t                 expected_q[$];
        int                             mismatches;
        int                             checked;
        int                             full_rejects;
        int                             empty_rejects;

        function new();
            peak_level    = '0;
            wait_total    = '0;
            exits         = '0;
            area_total    = '0;
            mismatches    = 0;
            checked       = 0;
            full_rejects  = 0;
            empty_rejects = 0;
        endfunction

        function int level();
            return held_tags.size();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Apply one accepted word to the queue state and queue up its result.
        function void note_request(fqos_pkg::req_t w);
            fqos_pkg::rsp_t r;
            r = '0;
            if (w.mode == fqos_pkg::MODE_ENQ)
            begin
                if (held_tags.size() >= fqos_pkg::DEPTH)
                begin
                    r.error = fqos_pkg::ERR_FULL;
                    full_rejects++;
                end
                else
                begin
                    held_tags.push_back(w.packet_tag);
                    held_times.push_back(w.now);
                    area_total -= {{(fqos_pkg::SUM_W-fqos_pkg::TIME_BITS){1'b0}}, w.now};
                    if (fqos_pkg::CNT_W'(held_tags.size()) > peak_level)
                        peak_level = fqos_pkg::CNT_W'(held_tags.size());
                end
            end
            else
            begin
                if (held_tags.size() == 0)
                begin
                    r.error = fqos_pkg::ERR_EMPTY;
                    empty_rejects++;
                end
                else
                begin
                    r.out_tag   = held_tags.pop_front();
                    // wraps modulo 2^TIME_BITS when time runs backwards
                    r.wait_time = w.now - held_times.pop_front();
                    wait_total += {{(fqos_pkg::SUM_W-fqos_pkg::TIME_BITS){1'b0}},
                                   r.wait_time};
                    exits++;
                    area_total += {{(fqos_pkg::SUM_W-fqos_pkg::TIME_BITS){1'b0}}, w.now};
                end
            end
            r.queue_size = fqos_pkg::CNT_W'(held_tags.size());
            r.max_size   = peak_level;
            r.wait_sum   = wait_total;
            r.exit_count = exits;
            r.area_sum   = area_total;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
            $display("mismatch at %0t ns: result %0d field %s got %0h want %0h",
                     $time, checked, field, got, want);
            mismatches++;
        endtask

        task check_result(fqos_pkg::rsp_t got);
            fqos_pkg::rsp_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected", 64'(got.queue_size), 64'd0);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.out_tag !== want.out_tag)
                report_mismatch("out_tag", 64'(got.out_tag), 64'(want.out_tag));
            if (got.wait_time !== want.wait_time)
                report_mismatch("wait_time", 64'(got.wait_time), 64'(want.wait_time));
            if (got.error !== want.error)
                report_mismatch("error", 64'(got.error), 64'(want.error));
            if (got.queue_size !== want.queue_size)
                report_mismatch("queue_size", 64'(got.queue_size), 64'(want.queue_size));
            if (got.max_size !== want.max_size)
                report_mismatch("max_size", 64'(got.max_size), 64'(want.max_size));
            if (got.wait_sum !== want.wait_sum)
                report_mismatch("wait_sum", got.wait_sum, want.wait_sum);
            if (got.exit_count !== want.exit_count)
                report_mismatch("exit_count", 64'(got.exit_count), 64'(want.exit_count));
            if (got.area_sum !== want.area_sum)
                report_mismatch("area_sum", got.area_sum, want.area_sum);
        endtask
    endclass

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    fqos_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    fqos_pkg::rsp_t rsp;

    int                             send_idle_pct  = 0;
    int                             recv_stall_pct = 0;
    logic                           filling        = 1'b1;
    logic [fqos_pkg::TIME_BITS-1:0] tick           = '0;

    queue_stats_scoreboard stats_sb = new();

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    fifo_queue_with_occupancy_stats_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Check on the pre-edge stall value, then pick the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            stats_sb.check_result(rsp);
        rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic fqos_pkg::req_t make_word(logic mode,
                                                 logic [fqos_pkg::TAG_BITS-1:0] tag,
                                                 logic [fqos_pkg::TIME_BITS-1:0] t);
        fqos_pkg::req_t w;
        w.mode       = mode;
        w.packet_tag = tag;
        w.now        = t;
        return w;
    endfunction

    // Mostly creep forward; now and then jump anywhere or step back.
    function logic [fqos_pkg::TIME_BITS-1:0] next_now();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            tick = $urandom();
        else if (pick < 10)
            tick = tick - $urandom_range(1, 5000);
        else
            tick = tick + $urandom_range(0, 60);
        return tick;
    endfunction

    task send_word(input fqos_pkg::req_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        stats_sb.note_request(w);
    endtask

    // Fill toward full with a few dequeues mixed in, then drain, so the index
    // wrap and the full reject come up.
    task run_random(input int count);
        int   lvl;
        int   enq_bias;
        logic mode;
        for (int i = 0; i < count; i++)
        begin
            lvl = stats_sb.level();
            if (filling && lvl == fqos_pkg::DEPTH && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && lvl == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b1;
            enq_bias = filling ? 97 : 3;
            mode = ($urandom_range(0, 99) < enq_bias) ? fqos_pkg::MODE_ENQ
                                                       : fqos_pkg::MODE_DEQ;
            send_word(make_word(mode, fqos_pkg::TAG_BITS'($urandom()), next_now()));
        end
    endtask

    initial
    begin
        send_idle_pct  = 17;
        recv_stall_pct = 87;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(make_word(fqos_pkg::MODE_DEQ, 16'h1234, 32'h0000_0010));
        send_word(make_word(fqos_pkg::MODE_ENQ, 16'h0000, 32'h0000_0000));
        send_word(make_word(fqos_pkg::MODE_ENQ, 16'hFFFF, 32'hFFFF_FFFF));
        send_word(make_word(fqos_pkg::MODE_ENQ, 16'hA5A5, 32'h0000_0064));
        send_word(make_word(fqos_pkg::MODE_ENQ, 16'h5A5A, 32'h8000_0000));
        send_word(make_word(fqos_pkg::MODE_DEQ, 16'hFFFF, 32'hFFFF_FFFF));
        send_word(make_word(fqos_pkg::MODE_DEQ, 16'h0000, 32'h0000_0005));
        send_word(make_word(fqos_pkg::MODE_DEQ, 16'h7777, 32'h0000_0032));
        send_word(make_word(fqos_pkg::MODE_DEQ, 16'h0001, 32'h7FFF_FFFF));
        send_word(make_word(fqos_pkg::MODE_DEQ, 16'hFFFF, 32'hFFFF_FFFF));
        send_word(make_word(fqos_pkg::MODE_ENQ, 16'h0001, 32'h0000_0007));
        send_word(make_word(fqos_pkg::MODE_DEQ, 16'h8000, 32'h0000_0007));
        tick = 32'h0000_0007;

        run_random(RANDOM_WORDS / 3);
        send_idle_pct  = 87;
        recv_stall_pct = 17;
        run_random(RANDOM_WORDS / 3);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));
        req_valid <= 1'b0;

        while (stats_sb.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("run: %0d results checked, %0d dequeues, peak occupancy %0d of %0d",
                 stats_sb.checked, stats_sb.exits, stats_sb.peak_level, fqos_pkg::DEPTH);
        $display("run: %0d enqueues rejected as full, %0d dequeues rejected as empty",
                 stats_sb.full_rejects, stats_sb.empty_rejects);
        if (stats_sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
